FILE: src/spq_pkg.sv
// Types, codes and constant scale tables for the scale pitch quantizer.
// No dependencies; used by spq_alu and scale_pitch_quantizer.
`default_nettype none

package spq_pkg;

    localparam logic [3:0] CHROMATIC = 4'd15;

    localparam logic [1:0] REQ_DEG_TO_MIDI = 2'd0;
    localparam logic [1:0] REQ_MIDI_TO_NOTE = 2'd1;
    localparam logic [1:0] REQ_CONVERT = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_MIDI_RANGE = 2'd2;

    localparam logic [1:0] ALU_ADD = 2'd0;
    localparam logic [1:0] ALU_SUB = 2'd1;
    localparam logic [1:0] ALU_ABSDIFF = 2'd2;

    localparam int ACC_W = 10;

    typedef logic signed [ACC_W-1:0] acc_t;

    typedef struct packed {
        logic [1:0] op;
        acc_t       a;
        acc_t       b;
    } alu_req_t;

    function automatic logic [3:0] scale_len(input logic [3:0] sc);
        logic [3:0] len;
        case (sc)
            4'd8:    len = 4'd6;
            4'd9:    len = 4'd5;
            4'd14:   len = 4'd6;
            4'd15:   len = 4'd12;
            default: len = 4'd7;
        endcase
        return len;
    endfunction

    // Entry i of a scale sits in nibble i of its row.
    function automatic logic [47:0] scale_row(input logic [3:0] sc);
        logic [47:0] row;
        case (sc)
            4'd0:    row = 48'h00000A875320;
            4'd1:    row = 48'h00000B975420;
            4'd2:    row = 48'h00000A975320;
            4'd3:    row = 48'h00000A875310;
            4'd4:    row = 48'h00000A975420;
            4'd5:    row = 48'h00000B975320;
            4'd6:    row = 48'h00000B875320;
            4'd7:    row = 48'h00000A975430;
            4'd8:    row = 48'h000000A76530;
            4'd9:    row = 48'h0000000A7530;
            4'd10:   row = 48'h00000B876320;
            4'd11:   row = 48'h00000A976320;
            4'd12:   row = 48'h00000B976410;
            4'd13:   row = 48'h00000B876310;
            4'd14:   row = 48'h000000A86420;
            default: row = 48'hBA9876543210;
        endcase
        return row;
    endfunction

    function automatic logic [3:0] scale_tone(input logic [3:0] sc, input logic [3:0] idx);
        logic [47:0] row;
        logic [3:0]  tone;
        row = scale_row(sc);
        if (idx < 4'd12) begin
            tone = row[{idx, 2'b00} +: 4];
        end
        else begin
            tone = 4'd0;
        end
        return tone;
    endfunction

endpackage

`default_nettype wire

FILE: src/spq_alu.sv
// Shared add, subtract and absolute-difference unit of the quantizer.
// Depends on spq_pkg for the request struct and operation codes.
`default_nettype none

module spq_alu (
    input  wire spq_pkg::alu_req_t req,
    output spq_pkg::acc_t          result
);

    spq_pkg::acc_t diff;

    assign diff = req.a - req.b;

    always_comb
    begin
        case (req.op)
            spq_pkg::ALU_ADD:     result = req.a + req.b;
            spq_pkg::ALU_SUB:     result = diff;
            spq_pkg::ALU_ABSDIFF: result = diff[spq_pkg::ACC_W-1] ? -diff : diff;
            default:              result = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: src/scale_pitch_quantizer.sv
// Top level of the scale pitch quantizer: sequencer, tonic register, result regs.
// Depends on spq_pkg and spq_alu.
//
// Usage:
//   Requests enter on start while busy is low; all request fields are sampled then.
//   The tonic is written over cfg_valid/cfg_ready/cfg_data; cfg_ready is always high.
//   Each result appears for one cycle with done high; the receiver cannot stall it.
//   Path from acceptance to done:
//     invalid request or degree, or conversion between scales of equal size: from idle;
//     degree to MIDI: through the add state;
//     conversion between scales of different size: the snap state over the target's tones;
//     MIDI to note: the divide state for the D octave steps of the divide by twelve
//     (at most 10), then the snap state over the L tones of the scale (at most 12).
//   Octave division, the MIDI sum and the snap search share one add/subtract/abs-diff
//   unit, one step a cycle: repeated subtraction or addition of twelve for the octave,
//   then one scale tone per cycle in the nearest-tone search. busy is high until the
//   result is produced, and a new request may be accepted in the cycle done is high.
//   Reset clears the sequencer, the strobe and the tonic (to 0).
`default_nettype none

module scale_pitch_quantizer #(
    parameter int BASE_OCTAVE = 1
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        start,
    output logic       busy,
    input  wire  [1:0] req_type,
    input  wire  [3:0] scale_sel,
    input  wire  [3:0] dest_scale,
    input  wire  [3:0] degree_in,
    input  wire  signed [4:0] octave_in,
    input  wire  [6:0] midi_in,
    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire  [3:0] cfg_data,
    output logic       done,
    output logic [6:0] midi_out,
    output logic [3:0] degree_out,
    output logic signed [4:0] octave_out,
    output logic [1:0] status
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ADD  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_SNAP = 2'd3;

    localparam spq_pkg::acc_t SEMIS = spq_pkg::ACC_W'(12);
    localparam spq_pkg::acc_t BASE  = spq_pkg::ACC_W'(BASE_OCTAVE);

    logic [1:0] state_reg, state_next;
    logic       done_reg, done_next;
    logic [3:0] tonic_reg, tonic_next;

    spq_pkg::acc_t     acc_reg, acc_next;
    spq_pkg::acc_t     addend_reg, addend_next;
    logic signed [4:0] q_reg, q_next;
    logic [3:0] snap_sc_reg, snap_sc_next;
    logic [3:0] semi_reg, semi_next;
    logic [3:0] idx_reg, idx_next;
    logic [3:0] best_reg, best_next;
    logic [3:0] bidx_reg, bidx_next;
    logic [6:0] midi_reg, midi_next;
    logic [3:0] deg_reg, deg_next;
    logic signed [4:0] oct_reg, oct_next;
    logic [1:0] status_reg, status_next;

    spq_pkg::alu_req_t alu_req;
    spq_pkg::acc_t     alu_res;

    logic          accept;
    logic [3:0]    sel_len;
    logic [3:0]    sel_tone;
    spq_pkg::acc_t oct_ext;
    spq_pkg::acc_t oct_base;
    logic [3:0]    snap_tone;
    logic [3:0]    cand_best;
    logic [3:0]    cand_idx;

    spq_alu u_alu (
        .req    (alu_req),
        .result (alu_res)
    );

    assign busy       = (state_reg != S_IDLE);
    assign accept     = start && !busy;
    assign cfg_ready  = 1'b1;
    assign done       = done_reg;
    assign midi_out   = midi_reg;
    assign degree_out = deg_reg;
    assign octave_out = oct_reg;
    assign status     = status_reg;

    assign sel_len   = spq_pkg::scale_len(scale_sel);
    assign sel_tone  = spq_pkg::scale_tone(scale_sel, degree_in);
    assign oct_ext   = spq_pkg::ACC_W'(octave_in);
    assign oct_base  = oct_ext + BASE;
    assign snap_tone = spq_pkg::scale_tone(snap_sc_reg, idx_reg);

    always_comb
    begin
        alu_req.op = spq_pkg::ALU_ADD;
        alu_req.a  = acc_reg;
        alu_req.b  = addend_reg;
        case (state_reg)
            S_DIV:
            begin
                alu_req.op = acc_reg[spq_pkg::ACC_W-1] ? spq_pkg::ALU_ADD : spq_pkg::ALU_SUB;
                alu_req.b  = SEMIS;
            end
            S_SNAP:
            begin
                alu_req.op = spq_pkg::ALU_ABSDIFF;
                alu_req.a  = spq_pkg::ACC_W'({1'b0, snap_tone});
                alu_req.b  = spq_pkg::ACC_W'({1'b0, semi_reg});
            end
            default:
            begin
                alu_req.op = spq_pkg::ALU_ADD;
            end
        endcase
    end

    always_comb
    begin
        if ((state_reg == S_SNAP) && (alu_res[3:0] < best_reg)) begin
            cand_best = alu_res[3:0];
            cand_idx  = idx_reg;
        end
        else begin
            cand_best = best_reg;
            cand_idx  = bidx_reg;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        done_next    = 1'b0;
        tonic_next   = tonic_reg;
        acc_next     = acc_reg;
        addend_next  = addend_reg;
        q_next       = q_reg;
        snap_sc_next = snap_sc_reg;
        semi_next    = semi_reg;
        idx_next     = idx_reg;
        best_next    = best_reg;
        bidx_next    = bidx_reg;
        midi_next    = midi_reg;
        deg_next     = deg_reg;
        oct_next     = oct_reg;
        status_next  = status_reg;

        if (cfg_valid && cfg_ready) begin
            tonic_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept) begin
                    midi_next   = 7'd0;
                    deg_next    = 4'd0;
                    oct_next    = 5'sd0;
                    status_next = spq_pkg::ST_OK;
                    idx_next    = 4'd0;
                    best_next   = 4'd12;
                    bidx_next   = 4'd0;
                    q_next      = 5'sd0;
                    case (req_type)
                        spq_pkg::REQ_DEG_TO_MIDI:
                        begin
                            if (degree_in >= sel_len) begin
                                status_next = spq_pkg::ST_BAD_INDEX;
                                done_next   = 1'b1;
                            end
                            else begin
                                acc_next    = (oct_base <<< 3) + (oct_base <<< 2);
                                addend_next = spq_pkg::ACC_W'({1'b0, sel_tone})
                                            + spq_pkg::ACC_W'({1'b0, tonic_reg});
                                state_next  = S_ADD;
                            end
                        end
                        spq_pkg::REQ_MIDI_TO_NOTE:
                        begin
                            acc_next     = spq_pkg::ACC_W'({1'b0, midi_in})
                                         - spq_pkg::ACC_W'({1'b0, tonic_reg});
                            snap_sc_next = scale_sel;
                            state_next   = S_DIV;
                        end
                        spq_pkg::REQ_CONVERT:
                        begin
                            if (degree_in >= sel_len) begin
                                status_next = spq_pkg::ST_BAD_INDEX;
                                done_next   = 1'b1;
                            end
                            else if (sel_len == spq_pkg::scale_len(dest_scale)) begin
                                deg_next  = degree_in;
                                done_next = 1'b1;
                            end
                            else begin
                                semi_next    = sel_tone;
                                snap_sc_next = dest_scale;
                                state_next   = S_SNAP;
                            end
                        end
                        default:
                        begin
                            status_next = spq_pkg::ST_BAD_INDEX;
                            done_next   = 1'b1;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                if (alu_res[spq_pkg::ACC_W-1]) begin
                    midi_next   = 7'd0;
                    status_next = spq_pkg::ST_MIDI_RANGE;
                end
                else if (alu_res > spq_pkg::ACC_W'(127)) begin
                    midi_next   = 7'd127;
                    status_next = spq_pkg::ST_MIDI_RANGE;
                end
                else begin
                    midi_next = alu_res[6:0];
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_DIV:
            begin
                if (acc_reg[spq_pkg::ACC_W-1]) begin
                    acc_next = alu_res;
                    q_next   = q_reg - 5'sd1;
                end
                else if (acc_reg >= SEMIS) begin
                    acc_next = alu_res;
                    q_next   = q_reg + 5'sd1;
                end
                else begin
                    semi_next  = acc_reg[3:0];
                    oct_next   = q_reg - BASE[4:0];
                    state_next = S_SNAP;
                end
            end
            S_SNAP:
            begin
                best_next = cand_best;
                bidx_next = cand_idx;
                if (idx_reg == spq_pkg::scale_len(snap_sc_reg) - 4'd1) begin
                    deg_next   = cand_idx;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else begin
                    idx_next = idx_reg + 4'd1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            tonic_reg <= 4'd0;
        end
        else begin
            state_reg <= state_next;
            done_reg  <= done_next;
            tonic_reg <= tonic_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        addend_reg  <= addend_next;
        q_reg       <= q_next;
        snap_sc_reg <= snap_sc_next;
        semi_reg    <= semi_next;
        idx_reg     <= idx_next;
        best_reg    <= best_next;
        bidx_reg    <= bidx_next;
        midi_reg    <= midi_next;
        deg_reg     <= deg_next;
        oct_reg     <= oct_next;
        status_reg  <= status_next;
    end

endmodule

`default_nettype wire

FILE: sim/scale_pitch_quantizer_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for scale_pitch_quantizer: directed and random requests under
// several tonic settings and sender idling rates, each result checked against a predictor.
// Depends on spq_pkg and the scale_pitch_quantizer RTL.

module scale_pitch_quantizer_test;

    localparam int BASE_OCTAVE = 1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 30;
    localparam int MAX_REPORTS = 10;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [6:0]        midi;
        logic [3:0]        degree;
        logic signed [4:0] octave;
        logic [1:0]        status;
    } note_result_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        req_type;
    logic [3:0]        scale_sel;
    logic [3:0]        dest_scale;
    logic [3:0]        degree_in;
    logic signed [4:0] octave_in;
    logic [6:0]        midi_in;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [3:0]        cfg_data;
    logic              done;
    logic [6:0]        midi_out;
    logic [3:0]        degree_out;
    logic signed [4:0] octave_out;
    logic [1:0]        status;

    logic [3:0]   tonic_setting;
    note_result_t expected_notes[$];
    int           mismatch_count;
    int           quiet_cycles;

    int scale_size [16] = '{7, 7, 7, 7, 7, 7, 7, 7, 6, 5, 7, 7, 7, 7, 6, 12};
    int tone_table [16][12] = '{
        '{0, 2, 3, 5, 7, 8, 10, 0, 0, 0, 0, 0},
        '{0, 2, 4, 5, 7, 9, 11, 0, 0, 0, 0, 0},
        '{0, 2, 3, 5, 7, 9, 10, 0, 0, 0, 0, 0},
        '{0, 1, 3, 5, 7, 8, 10, 0, 0, 0, 0, 0},
        '{0, 2, 4, 5, 7, 9, 10, 0, 0, 0, 0, 0},
        '{0, 2, 3, 5, 7, 9, 11, 0, 0, 0, 0, 0},
        '{0, 2, 3, 5, 7, 8, 11, 0, 0, 0, 0, 0},
        '{0, 3, 4, 5, 7, 9, 10, 0, 0, 0, 0, 0},
        '{0, 3, 5, 6, 7, 10, 0, 0, 0, 0, 0, 0},
        '{0, 3, 5, 7, 10, 0, 0, 0, 0, 0, 0, 0},
        '{0, 2, 3, 6, 7, 8, 11, 0, 0, 0, 0, 0},
        '{0, 2, 3, 6, 7, 9, 10, 0, 0, 0, 0, 0},
        '{0, 1, 4, 6, 7, 9, 11, 0, 0, 0, 0, 0},
        '{0, 1, 3, 6, 7, 8, 11, 0, 0, 0, 0, 0},
        '{0, 2, 4, 6, 8, 10, 0, 0, 0, 0, 0, 0},
        '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11}
    };

    scale_pitch_quantizer #(
        .BASE_OCTAVE(BASE_OCTAVE)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req_type(req_type),
        .scale_sel(scale_sel),
        .dest_scale(dest_scale),
        .degree_in(degree_in),
        .octave_in(octave_in),
        .midi_in(midi_in),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .done(done),
        .midi_out(midi_out),
        .degree_out(degree_out),
        .octave_out(octave_out),
        .status(status)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int nearest_degree(input logic [3:0] sc, input int semi);
        int best_gap;
        int best_idx;
        int gap;
        int i;
        best_gap = 12;
        best_idx = 0;
        for (i = 0; i < scale_size[sc]; i++)
        begin
            gap = tone_table[sc][i] - semi;
            if (gap < 0)
            begin
                gap = -gap;
            end
            if (gap < best_gap)
            begin
                best_gap = gap;
                best_idx = i;
            end
        end
        return best_idx;
    endfunction

    function automatic note_result_t quantize_request(
        input logic [1:0]        req,
        input logic [3:0]        sc,
        input logic [3:0]        tg,
        input logic [3:0]        deg,
        input logic signed [4:0] oct,
        input logic [6:0]        midi,
        input logic [3:0]        tonic
    );
        note_result_t r;
        int note;
        int octs;
        int pclass;
        r = '0;
        case (req)
            spq_pkg::REQ_DEG_TO_MIDI:
            begin
                if (deg >= scale_size[sc])
                begin
                    r.status = spq_pkg::ST_BAD_INDEX;
                end
                else
                begin
                    note = (int'(oct) + BASE_OCTAVE) * 12 + tone_table[sc][deg] + int'(tonic);
                    if (note < 0)
                    begin
                        r.status = spq_pkg::ST_MIDI_RANGE;
                        r.midi = 7'd0;
                    end
                    else if (note > 127)
                    begin
                        r.status = spq_pkg::ST_MIDI_RANGE;
                        r.midi = 7'd127;
                    end
                    else
                    begin
                        r.midi = 7'(note);
                    end
                end
            end
            spq_pkg::REQ_MIDI_TO_NOTE:
            begin
                note = int'(midi) - int'(tonic);
                octs = (note >= 0) ? note / 12 : -((11 - note) / 12);
                pclass = note - octs * 12;
                r.octave = 5'(octs - BASE_OCTAVE);
                r.degree = (sc == spq_pkg::CHROMATIC) ? 4'(pclass)
                                                      : 4'(nearest_degree(sc, pclass));
            end
            spq_pkg::REQ_CONVERT:
            begin
                if (deg >= scale_size[sc])
                begin
                    r.status = spq_pkg::ST_BAD_INDEX;
                end
                else if (tg == spq_pkg::CHROMATIC)
                begin
                    r.degree = 4'(tone_table[sc][deg]);
                end
                else if (scale_size[sc] == scale_size[tg])
                begin
                    r.degree = deg;
                end
                else
                begin
                    r.degree = 4'(nearest_degree(tg, tone_table[sc][deg]));
                end
            end
            default:
            begin
                r.status = spq_pkg::ST_BAD_INDEX;
            end
        endcase
        return r;
    endfunction

    task automatic send_request(
        input logic [1:0]        req,
        input logic [3:0]        sc,
        input logic [3:0]        tg,
        input logic [3:0]        deg,
        input logic signed [4:0] oct,
        input logic [6:0]        midi,
        input int                idle_pct
    );
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req_type <= req;
        scale_sel <= sc;
        dest_scale <= tg;
        degree_in <= deg;
        octave_in <= oct;
        midi_in <= midi;
        do
            @(posedge clk);
        while (busy);
        expected_notes.push_back(quantize_request(req, sc, tg, deg, oct, midi, tonic_setting));
    endtask

    task automatic drain_requests();
        start <= 1'b0;
        while (expected_notes.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_tonic(input logic [3:0] value);
        drain_requests();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        tonic_setting = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic test_degree_to_midi();
        send_request(spq_pkg::REQ_DEG_TO_MIDI, 4'd0, 4'd0, 4'd0, -5'sd1, 7'd0, 0);
        send_request(spq_pkg::REQ_DEG_TO_MIDI, 4'd15, 4'd0, 4'd11, 5'sd9, 7'd0, 0);
        send_request(spq_pkg::REQ_DEG_TO_MIDI, 4'd8, 4'd0, 4'd5, 5'sb10000, 7'd0, 0);
        send_request(spq_pkg::REQ_DEG_TO_MIDI, 4'd1, 4'd0, 4'd6, 5'sd4, 7'd0, 0);
        send_request(spq_pkg::REQ_DEG_TO_MIDI, 4'd0, 4'd0, 4'd7, 5'sd0, 7'd0, 0);
        send_request(spq_pkg::REQ_DEG_TO_MIDI, 4'd15, 4'd15, 4'd15, 5'sd15, 7'd127, 0);
    endtask

    task automatic test_midi_to_note();
        send_request(spq_pkg::REQ_MIDI_TO_NOTE, 4'd15, 4'd0, 4'd0, 5'sd0, 7'd0, 0);
        send_request(spq_pkg::REQ_MIDI_TO_NOTE, 4'd9, 4'd0, 4'd0, 5'sd0, 7'd127, 0);
        send_request(spq_pkg::REQ_MIDI_TO_NOTE, 4'd3, 4'd0, 4'd0, 5'sd0, 7'd64, 0);
        send_request(spq_pkg::REQ_MIDI_TO_NOTE, 4'd0, 4'd0, 4'd0, 5'sd0, 7'd71, 0);
    endtask

    task automatic test_convert_degree();
        send_request(spq_pkg::REQ_CONVERT, 4'd2, spq_pkg::CHROMATIC, 4'd6, 5'sd0, 7'd0, 0);
        send_request(spq_pkg::REQ_CONVERT, 4'd0, 4'd1, 4'd3, 5'sd0, 7'd0, 0);
        send_request(spq_pkg::REQ_CONVERT, 4'd14, 4'd8, 4'd5, 5'sd0, 7'd0, 0);
        send_request(spq_pkg::REQ_CONVERT, 4'd15, 4'd9, 4'd11, 5'sd0, 7'd0, 0);
        send_request(spq_pkg::REQ_CONVERT, 4'd8, 4'd0, 4'd6, 5'sd0, 7'd0, 0);
        send_request(spq_pkg::REQ_CONVERT, 4'd9, spq_pkg::CHROMATIC, 4'd4, 5'sd0, 7'd0, 0);
    endtask

    task automatic test_unused_request();
        send_request(REQ_UNUSED, 4'd5, 4'd3, 4'd2, 5'sd3, 7'd99, 0);
    endtask

    task automatic test_below_tonic();
        send_request(spq_pkg::REQ_MIDI_TO_NOTE, 4'd0, 4'd0, 4'd0, 5'sd0, 7'd0, 0);
        send_request(spq_pkg::REQ_MIDI_TO_NOTE, 4'd12, 4'd0, 4'd0, 5'sd0, 7'd14, 0);
        send_request(spq_pkg::REQ_MIDI_TO_NOTE, spq_pkg::CHROMATIC, 4'd0, 4'd0, 5'sd0, 7'd15, 0);
    endtask

    task automatic test_random_requests(input int count, input int idle_pct);
        logic [1:0]        req;
        logic [3:0]        sc;
        logic [3:0]        tg;
        logic [3:0]        deg;
        logic signed [4:0] oct;
        logic [6:0]        midi;
        repeat (count)
        begin
            req = ($urandom_range(99) < 5) ? REQ_UNUSED : 2'($urandom_range(2));
            sc = 4'($urandom_range(15));
            tg = 4'($urandom_range(15));
            deg = ($urandom_range(99) < 15) ? 4'($urandom_range(15))
                                            : 4'($urandom_range(scale_size[sc] - 1));
            oct = ($urandom_range(99) < 15) ? 5'($urandom_range(31))
                                            : 5'(int'($urandom_range(10)) - 1);
            midi = ($urandom_range(99) < 20) ? 7'($urandom_range(20)) : 7'($urandom_range(127));
            send_request(req, sc, tg, deg, oct, midi, idle_pct);
        end
    endtask

    always @(posedge clk)
    begin
        note_result_t expected_note;
        if (rst_n && done)
        begin
            if (expected_notes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                begin
                    $display("%0t: result with no request pending:", $realtime,
                             " midi %0d degree %0d octave %0d status %0d",
                             midi_out, degree_out, octave_out, status);
                end
            end
            else
            begin
                expected_note = expected_notes.pop_front();
                if (midi_out !== expected_note.midi || degree_out !== expected_note.degree ||
                    octave_out !== expected_note.octave || status !== expected_note.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("%0t: expected midi %0d degree %0d octave %0d status %0d,",
                                 $realtime, expected_note.midi, expected_note.degree,
                                 expected_note.octave, expected_note.status,
                                 " got midi %0d degree %0d octave %0d status %0d",
                                 midi_out, degree_out, octave_out, status);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("scale_pitch_quantizer_test: FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        mismatch_count = 0;
        tonic_setting = 4'd0;
        rst_n <= 1'b0;
        start <= 1'b0;
        req_type <= spq_pkg::REQ_DEG_TO_MIDI;
        scale_sel <= 4'd0;
        dest_scale <= 4'd0;
        degree_in <= 4'd0;
        octave_in <= 5'sd0;
        midi_in <= 7'd0;
        cfg_valid <= 1'b0;
        cfg_data <= 4'd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_degree_to_midi();
        test_midi_to_note();
        test_convert_degree();
        test_unused_request();

        write_tonic(4'd11);
        test_random_requests(250, 0);

        // tonic above the octave is used as given
        write_tonic(4'd15);
        test_below_tonic();
        test_random_requests(250, 81);

        write_tonic(4'd0);
        test_random_requests(250, 31);

        write_tonic(4'($urandom_range(15)));
        test_random_requests(250, 0);

        drain_requests();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_notes.size() == 0)
        begin
            $display("scale_pitch_quantizer_test: PASS");
        end
        else
        begin
            $display("scale_pitch_quantizer_test: FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
src/spq_pkg.sv
src/spq_alu.sv
src/scale_pitch_quantizer.sv
sim/scale_pitch_quantizer_test.sv
